// ----- design/kmps_pkg.sv -----
// ----------------------------------------------------------------------------
// kmps_pkg
// Shared constants, codes and the CRC-32 table function for the keyed
// minimum priority store.
// ----------------------------------------------------------------------------
package kmps_pkg;

   localparam int COUNT_W = 11;

   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [7:0]  BYTE_MASK = 8'hFF;

   localparam logic [2:0] MODE_ADD    = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_CHANGE = 3'd2;
   localparam logic [2:0] MODE_QUERY  = 3'd3;
   localparam logic [2:0] MODE_RMMIN  = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // reflected CRC-32 table entry
   function automatic logic [31:0] crc_entry(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int j = 0; j < 8; j++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- design/kmps_crc.sv -----
// ----------------------------------------------------------------------------
// kmps_crc
// Byte-serial CRC-32 (no final inversion) over a 64-bit key, least significant byte first,
// one table lookup per cycle.
// ----------------------------------------------------------------------------
module kmps_crc (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   output logic        done,
   output logic [31:0] hash
);

   logic [31:0] c_ff;
   logic [63:0] k_ff;
   logic [2:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            c_ff    <= kmps_pkg::CRC_INIT;
            k_ff    <= key;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            c_ff   <= kmps_pkg::crc_entry((c_ff[7:0] ^ k_ff[7:0]) & kmps_pkg::BYTE_MASK)
                      ^ (c_ff >> 8);
            k_ff   <= k_ff >> 8;
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign hash = c_ff;

endmodule

// ----- design/keyed_min_priority_store_top.sv -----
// ----------------------------------------------------------------------------
// keyed_min_priority_store_top
// Hashed keyed store with bucket chains and a tournament tree of bucket
// minima; reports the overall minimum after every item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | req_valid/req_ready | mode, key, value
//  rsp_     | out       | rsp_valid/rsp_ready | status, found, min_valid, min_key,
//           |           |                     | min_value, entry_count
//
// One item at a time through a sequencer; every memory read is registered and
// the sequencer waits a hold step for it. Item length grows with the hash, each
// chain entry visited and each tree level walked; a spare mode skips all of these,
// and a long chain of duplicate keys can stretch an item far beyond the rest.
// After reset a clearing pass sweeps all 2*BUCKETS tree nodes and the bucket heads.
// A waiting result holds the sequencer in its last step until rsp_ready.
module keyed_min_priority_store_top #(
   parameter int BUCKETS = 256,
   parameter int ENTRIES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [63:0]        req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic               rsp_min_valid,
   output logic [63:0]        rsp_min_key,
   output logic signed [31:0] rsp_min_value,
   output logic [10:0]        rsp_entry_count
);

   localparam int AW   = $clog2(ENTRIES);
   localparam int EW   = $clog2(ENTRIES + 1);
   localparam int BW   = $clog2(BUCKETS);
   localparam int TW   = BW + 1;
   localparam int CntW = kmps_pkg::COUNT_W;
   localparam logic [EW-1:0] NONE = EW'(ENTRIES);
   localparam logic [TW-1:0] ROOT = TW'(1);

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_HASH, S_FIND, S_FIND_HEAD, S_FIND_CHK, S_FIND_CMP,
      S_NOTFOUND, S_FOUND, S_RMV, S_RMV_LEAF, S_RMV_FREE,
      S_MR, S_MR_HEAD, S_MR_CHK, S_MR_CMP, S_MR_LEAF, S_MR_UP, S_MR_PAR,
      S_MR_SIB, S_MR_SIBV,
      S_ADD, S_ADD_POP, S_ADD_HEAD, S_ADD_LINK, S_ADD_LEAF, S_ADD_LV,
      S_MA, S_MA_UP, S_MA_T, S_MA_TV,
      S_RM_ROOT, S_RM_KEY, S_FIN, S_FIN_ROOT, S_OUT
   } state_type;

   state_type          state_ff;
   logic               hold_ff;
   logic [2:0]         mode_ff;
   logic [63:0]        key_ff;
   logic signed [31:0] value_ff;
   logic [BW-1:0]      b_ff;
   logic [EW-1:0]      cur_ff, prev_ff, tgt_ff, enext_ff, win_ff;
   logic signed [31:0] winv_ff;
   logic [EW-1:0]      free_ff, fresh_ff, count_ff;
   logic [TW-1:0]      n_ff, clr_ff;
   logic               cbit_ff, by_idx_ff;
   logic [1:0]         status_ff;
   logic               found_ff;

   // memory ports
   logic [AW-1:0]      ent_ra_ff, ent_wa_ff, next_wa_ff;
   logic               ent_we_ff, next_we_ff, head_we_ff, tree_we_ff;
   logic [EW-1:0]      next_wd_ff, head_wd_ff, tree_wd_ff;
   logic [BW-1:0]      head_ra_ff, head_wa_ff;
   logic [TW-1:0]      tree_ra_ff, tree_wa_ff;
   logic [63:0]        key_rd_ff;
   logic signed [31:0] val_rd_ff;
   logic [EW-1:0]      next_rd_ff, head_rd_ff, tree_rd_ff;

   logic [63:0]        key_mem  [ENTRIES];
   logic signed [31:0] val_mem  [ENTRIES];
   logic [EW-1:0]      next_mem [ENTRIES];
   logic [EW-1:0]      head_mem [BUCKETS];
   logic [EW-1:0]      tree_mem [2*BUCKETS];

   // response register
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_found_ff, rsp_min_valid_ff;
   logic [63:0]        rsp_min_key_ff;
   logic signed [31:0] rsp_min_value_ff;
   logic [CntW-1:0]    rsp_count_ff;

   logic               accept, crc_start, crc_done;
   logic [63:0]        crc_key;
   logic [31:0]        crc_hash;
   logic [TW-1:0]      leaf;
   logic               mr_sib_win;

   assign req_ready = (state_ff == S_IDLE) && !hold_ff;
   assign accept    = req_valid && req_ready;
   assign crc_start = (accept && (req_mode <= kmps_pkg::MODE_QUERY))
                      || (state_ff == S_RM_KEY && !hold_ff);
   assign crc_key   = (state_ff == S_RM_KEY) ? key_rd_ff : req_key;
   assign leaf      = TW'(BUCKETS) + TW'(b_ff);
   // sibling beats current winner; right child wins ties
   assign mr_sib_win = cbit_ff ? (val_rd_ff < winv_ff) : !(winv_ff < val_rd_ff);

   kmps_crc u_crc (
      .clock (clock),
      .reset (reset),
      .start (crc_start),
      .key   (crc_key),
      .done  (crc_done),
      .hash  (crc_hash)
   );

   always_ff @(posedge clock) begin
      if (ent_we_ff) begin
         key_mem[ent_wa_ff] <= key_ff;
         val_mem[ent_wa_ff] <= value_ff;
      end
      if (next_we_ff) next_mem[next_wa_ff] <= next_wd_ff;
      key_rd_ff  <= key_mem[ent_ra_ff];
      val_rd_ff  <= val_mem[ent_ra_ff];
      next_rd_ff <= next_mem[ent_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (head_we_ff) head_mem[head_wa_ff] <= head_wd_ff;
      head_rd_ff <= head_mem[head_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (tree_we_ff) tree_mem[tree_wa_ff] <= tree_wd_ff;
      tree_rd_ff <= tree_mem[tree_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         hold_ff      <= 1'b0;
         clr_ff       <= '0;
         free_ff      <= NONE;
         fresh_ff     <= '0;
         count_ff     <= '0;
         ent_we_ff    <= 1'b0;
         next_we_ff   <= 1'b0;
         head_we_ff   <= 1'b0;
         tree_we_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ent_we_ff  <= 1'b0;
         next_we_ff <= 1'b0;
         head_we_ff <= 1'b0;
         tree_we_ff <= 1'b0;
         // the output step reloads the register itself
         if (rsp_valid_ff && rsp_ready && !(state_ff == S_OUT && !hold_ff))
            rsp_valid_ff <= 1'b0;
         if (hold_ff) begin
            hold_ff <= 1'b0;
         end else begin
            case (state_ff)
               S_CLEAR: begin
                  tree_we_ff <= 1'b1;
                  tree_wa_ff <= clr_ff;
                  tree_wd_ff <= NONE;
                  if (clr_ff < TW'(BUCKETS)) begin
                     head_we_ff <= 1'b1;
                     head_wa_ff <= clr_ff[BW-1:0];
                     head_wd_ff <= NONE;
                  end
                  clr_ff <= clr_ff + TW'(1);
                  if (clr_ff == TW'(2*BUCKETS - 1)) state_ff <= S_IDLE;
               end
               S_IDLE: begin
                  if (accept) begin
                     mode_ff   <= req_mode;
                     key_ff    <= req_key;
                     value_ff  <= req_value;
                     status_ff <= kmps_pkg::ST_OK;
                     found_ff  <= 1'b0;
                     by_idx_ff <= 1'b0;
                     if (req_mode <= kmps_pkg::MODE_QUERY) begin
                        state_ff <= S_HASH;
                     end else if (req_mode == kmps_pkg::MODE_RMMIN) begin
                        tree_ra_ff <= ROOT;
                        hold_ff    <= 1'b1;
                        state_ff   <= S_RM_ROOT;
                     end else begin
                        state_ff <= S_FIN;
                     end
                  end
               end
               S_HASH: begin
                  if (crc_done) begin
                     b_ff     <= BW'(crc_hash & 32'(BUCKETS - 1));
                     state_ff <= (mode_ff == kmps_pkg::MODE_ADD) ? S_ADD : S_FIND;
                  end
               end
               // ---- bucket search ----
               S_FIND: begin
                  head_ra_ff <= b_ff;
                  hold_ff    <= 1'b1;
                  state_ff   <= S_FIND_HEAD;
               end
               S_FIND_HEAD: begin
                  cur_ff   <= head_rd_ff;
                  prev_ff  <= NONE;
                  state_ff <= S_FIND_CHK;
               end
               S_FIND_CHK: begin
                  if (cur_ff == NONE) begin
                     state_ff <= S_NOTFOUND;
                  end else begin
                     ent_ra_ff <= cur_ff[AW-1:0];
                     hold_ff   <= 1'b1;
                     state_ff  <= S_FIND_CMP;
                  end
               end
               S_FIND_CMP: begin
                  if (by_idx_ff ? (cur_ff == tgt_ff) : (key_rd_ff == key_ff)) begin
                     tgt_ff   <= cur_ff;
                     enext_ff <= next_rd_ff;
                     state_ff <= S_FOUND;
                  end else begin
                     prev_ff  <= cur_ff;
                     cur_ff   <= next_rd_ff;
                     state_ff <= S_FIND_CHK;
                  end
               end
               S_NOTFOUND: begin
                  if (by_idx_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     status_ff <= kmps_pkg::ST_MISS;
                     state_ff  <= (mode_ff == kmps_pkg::MODE_CHANGE) ? S_ADD : S_FIN;
                  end
               end
               S_FOUND: begin
                  found_ff <= 1'b1;
                  state_ff <= (mode_ff == kmps_pkg::MODE_QUERY) ? S_FIN : S_RMV;
               end
               // ---- unlink and release ----
               S_RMV: begin
                  if (prev_ff != NONE) begin
                     next_we_ff <= 1'b1;
                     next_wa_ff <= prev_ff[AW-1:0];
                     next_wd_ff <= enext_ff;
                  end else begin
                     head_we_ff <= 1'b1;
                     head_wa_ff <= b_ff;
                     head_wd_ff <= enext_ff;
                  end
                  tree_ra_ff <= leaf;
                  hold_ff    <= 1'b1;
                  state_ff   <= S_RMV_LEAF;
               end
               S_RMV_LEAF: begin
                  state_ff <= (tree_rd_ff == tgt_ff) ? S_MR : S_RMV_FREE;
               end
               S_RMV_FREE: begin
                  next_we_ff <= 1'b1;
                  next_wa_ff <= tgt_ff[AW-1:0];
                  next_wd_ff <= free_ff;
                  free_ff    <= tgt_ff;
                  if (count_ff != '0) count_ff <= count_ff - EW'(1);
                  state_ff <= (mode_ff == kmps_pkg::MODE_CHANGE) ? S_ADD : S_FIN;
               end
               // ---- rescan bucket minimum, repair tree upward ----
               S_MR: begin
                  head_ra_ff <= b_ff;
                  hold_ff    <= 1'b1;
                  state_ff   <= S_MR_HEAD;
               end
               S_MR_HEAD: begin
                  cur_ff   <= head_rd_ff;
                  win_ff   <= NONE;
                  state_ff <= S_MR_CHK;
               end
               S_MR_CHK: begin
                  if (cur_ff == NONE) begin
                     state_ff <= S_MR_LEAF;
                  end else begin
                     ent_ra_ff <= cur_ff[AW-1:0];
                     hold_ff   <= 1'b1;
                     state_ff  <= S_MR_CMP;
                  end
               end
               S_MR_CMP: begin
                  if (win_ff == NONE || val_rd_ff < winv_ff) begin
                     win_ff  <= cur_ff;
                     winv_ff <= val_rd_ff;
                  end
                  cur_ff   <= next_rd_ff;
                  state_ff <= S_MR_CHK;
               end
               S_MR_LEAF: begin
                  tree_we_ff <= 1'b1;
                  tree_wa_ff <= leaf;
                  tree_wd_ff <= win_ff;
                  n_ff       <= leaf;
                  state_ff   <= S_MR_UP;
               end
               S_MR_UP: begin
                  if (n_ff <= ROOT) begin
                     state_ff <= S_RMV_FREE;
                  end else begin
                     cbit_ff    <= n_ff[0];
                     n_ff       <= n_ff >> 1;
                     tree_ra_ff <= n_ff >> 1;
                     hold_ff    <= 1'b1;
                     state_ff   <= S_MR_PAR;
                  end
               end
               S_MR_PAR: begin
                  if (tree_rd_ff != tgt_ff) begin
                     state_ff <= S_RMV_FREE;
                  end else begin
                     tree_ra_ff <= {n_ff[TW-2:0], ~cbit_ff};
                     hold_ff    <= 1'b1;
                     state_ff   <= S_MR_SIB;
                  end
               end
               S_MR_SIB: begin
                  if (tree_rd_ff == NONE) begin
                     tree_we_ff <= 1'b1;
                     tree_wa_ff <= n_ff;
                     tree_wd_ff <= win_ff;
                     state_ff   <= S_MR_UP;
                  end else begin
                     cur_ff    <= tree_rd_ff;
                     ent_ra_ff <= tree_rd_ff[AW-1:0];
                     hold_ff   <= 1'b1;
                     state_ff  <= S_MR_SIBV;
                  end
               end
               S_MR_SIBV: begin
                  tree_we_ff <= 1'b1;
                  tree_wa_ff <= n_ff;
                  if (win_ff == NONE || mr_sib_win) begin
                     tree_wd_ff <= cur_ff;
                     win_ff     <= cur_ff;
                     winv_ff    <= val_rd_ff;
                  end else begin
                     tree_wd_ff <= win_ff;
                  end
                  state_ff <= S_MR_UP;
               end
               // ---- insert at bucket head ----
               S_ADD: begin
                  if (count_ff >= EW'(ENTRIES)) begin
                     status_ff <= kmps_pkg::ST_FULL;
                     state_ff  <= S_FIN;
                  end else if (free_ff != NONE) begin
                     tgt_ff    <= free_ff;
                     ent_ra_ff <= free_ff[AW-1:0];
                     hold_ff   <= 1'b1;
                     state_ff  <= S_ADD_POP;
                  end else begin
                     tgt_ff   <= fresh_ff;
                     fresh_ff <= fresh_ff + EW'(1);
                     state_ff <= S_ADD_HEAD;
                  end
               end
               S_ADD_POP: begin
                  free_ff  <= next_rd_ff;
                  state_ff <= S_ADD_HEAD;
               end
               S_ADD_HEAD: begin
                  head_ra_ff <= b_ff;
                  hold_ff    <= 1'b1;
                  state_ff   <= S_ADD_LINK;
               end
               S_ADD_LINK: begin
                  ent_we_ff  <= 1'b1;
                  ent_wa_ff  <= tgt_ff[AW-1:0];
                  next_we_ff <= 1'b1;
                  next_wa_ff <= tgt_ff[AW-1:0];
                  next_wd_ff <= head_rd_ff;
                  head_we_ff <= 1'b1;
                  head_wa_ff <= b_ff;
                  head_wd_ff <= tgt_ff;
                  count_ff   <= count_ff + EW'(1);
                  tree_ra_ff <= leaf;
                  hold_ff    <= 1'b1;
                  state_ff   <= S_ADD_LEAF;
               end
               S_ADD_LEAF: begin
                  if (tree_rd_ff == NONE) begin
                     state_ff <= S_MA;
                  end else begin
                     ent_ra_ff <= tree_rd_ff[AW-1:0];
                     hold_ff   <= 1'b1;
                     state_ff  <= S_ADD_LV;
                  end
               end
               S_ADD_LV: begin
                  state_ff <= (value_ff < val_rd_ff) ? S_MA : S_FIN;
               end
               S_MA: begin
                  tree_we_ff <= 1'b1;
                  tree_wa_ff <= leaf;
                  tree_wd_ff <= tgt_ff;
                  n_ff       <= leaf;
                  state_ff   <= S_MA_UP;
               end
               S_MA_UP: begin
                  if (n_ff <= ROOT) begin
                     state_ff <= S_FIN;
                  end else begin
                     n_ff       <= n_ff >> 1;
                     tree_ra_ff <= n_ff >> 1;
                     hold_ff    <= 1'b1;
                     state_ff   <= S_MA_T;
                  end
               end
               S_MA_T: begin
                  if (tree_rd_ff == NONE) begin
                     tree_we_ff <= 1'b1;
                     tree_wa_ff <= n_ff;
                     tree_wd_ff <= tgt_ff;
                     state_ff   <= S_MA_UP;
                  end else begin
                     ent_ra_ff <= tree_rd_ff[AW-1:0];
                     hold_ff   <= 1'b1;
                     state_ff  <= S_MA_TV;
                  end
               end
               S_MA_TV: begin
                  // rises only while strictly smaller
                  if (value_ff >= val_rd_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     tree_we_ff <= 1'b1;
                     tree_wa_ff <= n_ff;
                     tree_wd_ff <= tgt_ff;
                     state_ff   <= S_MA_UP;
                  end
               end
               // ---- remove minimum ----
               S_RM_ROOT: begin
                  if (tree_rd_ff == NONE) begin
                     status_ff <= kmps_pkg::ST_MISS;
                     state_ff  <= S_FIN;
                  end else begin
                     found_ff  <= 1'b1;
                     by_idx_ff <= 1'b1;
                     tgt_ff    <= tree_rd_ff;
                     ent_ra_ff <= tree_rd_ff[AW-1:0];
                     hold_ff   <= 1'b1;
                     state_ff  <= S_RM_KEY;
                  end
               end
               S_RM_KEY: begin
                  state_ff <= S_HASH;
               end
               // ---- report ----
               S_FIN: begin
                  tree_ra_ff <= ROOT;
                  hold_ff    <= 1'b1;
                  state_ff   <= S_FIN_ROOT;
               end
               S_FIN_ROOT: begin
                  cur_ff    <= tree_rd_ff;
                  ent_ra_ff <= tree_rd_ff[AW-1:0];
                  hold_ff   <= 1'b1;
                  state_ff  <= S_OUT;
               end
               S_OUT: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_ff     <= 1'b1;
                     rsp_status_ff    <= status_ff;
                     rsp_found_ff     <= found_ff;
                     rsp_min_valid_ff <= (cur_ff != NONE);
                     rsp_min_key_ff   <= (cur_ff != NONE) ? key_rd_ff : 64'd0;
                     rsp_min_value_ff <= (cur_ff != NONE) ? val_rd_ff : 32'sd0;
                     rsp_count_ff     <= CntW'(count_ff);
                     state_ff         <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_min_valid   = rsp_min_valid_ff;
   assign rsp_min_key     = rsp_min_key_ff;
   assign rsp_min_value   = rsp_min_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= EW'(ENTRIES))
      else $error("entry count above capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready while an item is in progress");

   a_empty_min_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_min_valid_ff |->
         rsp_min_key_ff == 64'd0 && rsp_min_value_ff == 32'sd0)
      else $error("minimum fields not cleared for empty store");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == kmps_pkg::ST_FULL |-> rsp_count_ff == CntW'(ENTRIES))
      else $error("pool full reported below capacity");

endmodule
